@@ rtl/dsw_pkg.sv @@
// Package for the dice sum ways counter: widths, the prime modulus, default sizes
// and the shared modular window-update function.
// Has no dependencies. The top level takes it in by a wildcard import.
package dsw_pkg;

  // Field widths fixed by the interface.
  localparam int DICE_W  = 5;
  localparam int FACE_W  = 5;
  localparam int TGT_W   = 10;
  localparam int WAYS_W  = 30;

  // Default sizes for the top-level parameters.
  localparam int DEF_MAX_DICE   = 30;
  localparam int DEF_MAX_TARGET = 1023;

  // Prime modulus for all counts.
  localparam logic [WAYS_W-1:0] PRIME_MOD = WAYS_W'(1000000007);

  // One window step: (win + add_val - sub_val) mod PRIME_MOD. All operands are
  // below the prime, so the raw sum lies in (-PRIME_MOD, 2*PRIME_MOD) and one
  // correction by the prime in either direction suffices.
  function automatic logic [WAYS_W-1:0] mod_window(
    input logic [WAYS_W-1:0] win,
    input logic [WAYS_W-1:0] add_val,
    input logic [WAYS_W-1:0] sub_val,
    input logic              sub_en
  );
    logic signed [WAYS_W+1:0] raw;
    logic signed [WAYS_W+1:0] sub_ext;
    logic signed [WAYS_W+1:0] prime_ext;
    logic signed [WAYS_W+1:0] fixed;
    sub_ext   = sub_en ? $signed({2'b00, sub_val}) : '0;
    prime_ext = $signed({2'b00, PRIME_MOD});
    raw       = $signed({2'b00, win}) + $signed({2'b00, add_val}) - sub_ext;
    if (raw < 0) begin
      fixed = raw + prime_ext;
    end else if (raw >= prime_ext) begin
      fixed = raw - prime_ext;
    end else begin
      fixed = raw;
    end
    return fixed[WAYS_W-1:0];
  endfunction

endpackage

@@ rtl/dice_sum_ways_counter.sv @@
// Dice sum ways counter: counts ordered dice rolls reaching a target sum, mod 1e9+7.
// Depends on dsw_pkg for widths, the modulus and the window-update function.
// After transfer in, the sequencer fills row 0, then for each die runs DSTART, a row pass
// and DRAIN (DSTART alone when t is zero), then RES_RD, RES_WAIT and FIN; a rejected item goes to FIN.
// The rate is set by the row store's single write port and the one shared window
// adder, which produce one row entry per cycle. A new item is taken once the result
// has moved to the output register.
// Reset (rst_n low, synchronous) clears the sequencer and output valid; the row
// store is not cleared, as every item writes its rows before reading them.
module dice_sum_ways_counter
  import dsw_pkg::*;
#(
  parameter int MAX_DICE   = DEF_MAX_DICE,
  parameter int MAX_TARGET = DEF_MAX_TARGET
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DICE_W-1:0] in_dice_count,
  input  logic [FACE_W-1:0] in_face_count,
  input  logic [TGT_W-1:0]  in_target_sum,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WAYS_W-1:0] out_ways
);

  // Derived widths: row index, die counter and the comparison widths.
  localparam int IW        = (MAX_TARGET > 1) ? $clog2(MAX_TARGET + 1) : 1;
  localparam int DW        = (MAX_DICE > 1) ? $clog2(MAX_DICE + 1) : 1;
  localparam int DCW       = (DW > DICE_W) ? DW : DICE_W;
  localparam int TCW       = (IW > TGT_W) ? IW : TGT_W;
  localparam int FCW       = (IW > FACE_W) ? IW : FACE_W;
  localparam int MEM_DEPTH = 2 ** (IW + 1);

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_INIT     = 8'b0000_0010,
    ST_DSTART   = 8'b0000_0100,
    ST_PASS     = 8'b0000_1000,
    ST_DRAIN    = 8'b0001_0000,
    ST_RES_RD   = 8'b0010_0000,
    ST_RES_WAIT = 8'b0100_0000,
    ST_FIN      = 8'b1000_0000
  } state_t;

  // Control registers.
  state_t            state_r, state_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [DW-1:0]     die_r, die_nxt;
  logic              cur_r, cur_nxt;
  logic [WAYS_W-1:0] window_r, window_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [IW-1:0]     tgt_r;
  logic [DW-1:0]     dice_r;
  logic [FACE_W-1:0] faces_r;
  logic [IW-1:0]     pend_s_r;
  logic              pend_sub_r;
  logic [WAYS_W-1:0] res_r;
  logic [WAYS_W-1:0] out_ways_r;

  // Row store: two ping-pong rows, the row select is the top address bit.
  logic [WAYS_W-1:0] row_mem [MEM_DEPTH];
  logic [WAYS_W-1:0] rd_a_r, rd_b_r;
  logic [IW:0]       rd_a_addr, rd_b_addr, wr_addr;
  logic [WAYS_W-1:0] wr_data;
  logic              wr_en;

  // Input decode and range checks.
  logic [DCW-1:0] dice_ext;
  logic [TCW-1:0] tgt_ext;
  logic           reject;
  logic           in_xfer;
  logic           out_load;

  // Window arithmetic for the current pass.
  logic [IW-1:0]     rs_m1;
  logic [IW-1:0]     idx_b;
  logic              rs_gt_f;
  logic [WAYS_W-1:0] win_next_val;
  logic [DW-1:0]     die_inc;
  logic              last_die;

  assign dice_ext = DCW'(in_dice_count);
  assign tgt_ext  = TCW'(in_target_sum);
  assign reject   = (dice_ext > DCW'(MAX_DICE)) || (tgt_ext > TCW'(MAX_TARGET));
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  assign rs_m1        = IW'(idx_r - 1'b1);
  assign rs_gt_f      = FCW'(idx_r) > FCW'(faces_r);
  assign idx_b        = IW'(FCW'(idx_r) - FCW'(1) - FCW'(faces_r));
  assign win_next_val = mod_window(window_r, rd_a_r, rd_b_r, pend_sub_r);
  assign die_inc      = DW'(die_r + 1'b1);
  assign last_die     = (die_inc == dice_r);

  // Read addresses: previous row at s-1 and s-1-faces, or the final entry.
  assign rd_a_addr = {cur_r, (state_r == ST_RES_RD) ? tgt_r : rs_m1};
  assign rd_b_addr = {cur_r, idx_b};

  // Write port: row 0 fill, entry 0 of the new row, or a finished window entry.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {~cur_r, pend_s_r};
    wr_data = win_next_val;
    if (state_r == ST_INIT) begin
      wr_en   = 1'b1;
      wr_addr = {1'b0, idx_r};
      wr_data = (idx_r == '0) ? WAYS_W'(1) : '0;
    end else if (state_r == ST_DSTART) begin
      wr_en   = 1'b1;
      wr_addr = {~cur_r, IW'(0)};
      wr_data = '0;
    end else if (pend_vld_r) begin
      wr_en   = 1'b1;
    end
  end

  // Row store access, reads registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[wr_addr] <= wr_data;
    end
    rd_a_r <= row_mem[rd_a_addr];
    rd_b_r <= row_mem[rd_b_addr];
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    die_nxt       = die_r;
    cur_nxt       = cur_r;
    window_nxt    = window_r;
    pend_vld_nxt  = (state_r == ST_PASS);
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pend_vld_r) begin
      window_nxt = win_next_val;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          idx_nxt   = '0;
          die_nxt   = '0;
          cur_nxt   = 1'b0;
          state_nxt = reject ? ST_FIN : ST_INIT;
        end
      end
      ST_INIT: begin
        if (idx_r == tgt_r) begin
          state_nxt = (dice_r == '0) ? ST_RES_RD : ST_DSTART;
        end else begin
          idx_nxt = IW'(idx_r + 1'b1);
        end
      end
      ST_DSTART: begin
        window_nxt = '0;
        idx_nxt    = IW'(1);
        if (tgt_r == '0) begin
          cur_nxt   = ~cur_r;
          die_nxt   = die_inc;
          state_nxt = last_die ? ST_RES_RD : ST_DSTART;
        end else begin
          state_nxt = ST_PASS;
        end
      end
      ST_PASS: begin
        if (idx_r == tgt_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = IW'(idx_r + 1'b1);
        end
      end
      ST_DRAIN: begin
        cur_nxt   = ~cur_r;
        die_nxt   = die_inc;
        state_nxt = last_die ? ST_RES_RD : ST_DSTART;
      end
      ST_RES_RD: begin
        state_nxt = ST_RES_WAIT;
      end
      ST_RES_WAIT: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      die_r       <= '0;
      cur_r       <= 1'b0;
      window_r    <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      die_r       <= die_nxt;
      cur_r       <= cur_nxt;
      window_r    <= window_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: item fields, pending entry, result and output data.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tgt_r   <= IW'(tgt_ext);
      dice_r  <= DW'(dice_ext);
      faces_r <= in_face_count;
    end
    if (in_xfer && reject) begin
      res_r <= '0;
    end else if (state_r == ST_RES_WAIT) begin
      res_r <= rd_a_r;
    end
    if (state_r == ST_PASS) begin
      pend_s_r   <= idx_r;
      pend_sub_r <= rs_gt_f;
    end
    if (out_load) begin
      out_ways_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ways  = out_ways_r;

`ifndef NO_ASSERTIONS
  // A pending window entry exists only during or right after a pass.
  a_pend_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (state_r == ST_PASS || state_r == ST_DRAIN))
    else $error("window entry pending outside a row pass");

  // The pass index stays within 1..target.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PASS) |-> (idx_r != '0 && idx_r <= tgt_r))
    else $error("row pass index out of range");

  // While dice are being processed, fewer than the requested dice are done.
  a_die_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DSTART || state_r == ST_PASS || state_r == ST_DRAIN)
      |-> (die_r < dice_r))
    else $error("die counter passed the dice count");

  // A rejected item goes straight to the result with zero ways.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && reject) |=> (state_r == ST_FIN && res_r == '0))
    else $error("rejected item did not yield zero ways");

  // Every delivered count is reduced modulo the prime.
  a_out_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ways_r < PRIME_MOD))
    else $error("result not reduced modulo the prime");
`endif

endmodule
